// File: src/buddy_block_allocator_macros.svh
// Assertion macros shared by the buddy block allocator.
// Depends on signals named clk and rst in the including scope.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bba_pkg.sv
// Package for the buddy block allocator: field widths, defaults,
// sequencer operation codes and the controller/datapath structs.
package bba_pkg;

  localparam int SIZE_CLASSES_DEF = 4;
  localparam int FRAME_COUNT_DEF  = 64;
  localparam int ADDR_FIELD_W     = 10;
  localparam int CLASS_FIELD_W    = 3;
  localparam int THR_W            = 11;
  localparam int LEN_W            = 11;
  localparam int MARK_CLASS_W     = 3;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(16);
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [3:0] {
    OP_CLEAR,
    OP_IDLE,
    OP_SCAN,
    OP_FRAME_LD,
    OP_SPLIT,
    OP_PUSH0,
    OP_PUSH1,
    OP_REM0,
    OP_REM1,
    OP_REM2,
    OP_FSTART,
    OP_FMARK,
    OP_FLOOP,
    OP_MEVAL,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accept;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_free;
    logic mode_free;
    logic oor;
    logic scan_hit;
    logic cls_top;
    logic ret_avail;
    logic fresh_avail;
    logic split_more;
    logic marked;
    logic merge_ok;
    logic clear_last;
    logic out_busy;
  } stat_t;

endpackage

// File: src/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/bba_ctrl.sv
// Sequencer of the buddy block allocator.
// Depends on bba_pkg; drives bba_dp through cmd_t, reads stat_t.
module bba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bba_pkg::stat_t stat,
  output bba_pkg::cmd_t  cmd
);

  bba_pkg::op_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::OP_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.op       = state;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      bba_pkg::OP_CLEAR: begin
        if (stat.clear_last) state_next = bba_pkg::OP_IDLE;
      end
      bba_pkg::OP_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = stat.in_free ? bba_pkg::OP_FSTART : bba_pkg::OP_SCAN;
        end
      end
      bba_pkg::OP_SCAN: begin
        if (stat.scan_hit) begin
          state_next = bba_pkg::OP_REM0;
        end else if (stat.cls_top) begin
          if (stat.ret_avail) state_next = bba_pkg::OP_FRAME_LD;
          else if (stat.fresh_avail) state_next = bba_pkg::OP_SPLIT;
          else state_next = bba_pkg::OP_FINISH;
        end
      end
      bba_pkg::OP_FRAME_LD: state_next = bba_pkg::OP_SPLIT;
      bba_pkg::OP_SPLIT: begin
        state_next = stat.split_more ? bba_pkg::OP_PUSH0 : bba_pkg::OP_FINISH;
      end
      bba_pkg::OP_PUSH0: state_next = bba_pkg::OP_PUSH1;
      bba_pkg::OP_PUSH1: begin
        state_next = stat.mode_free ? bba_pkg::OP_FINISH : bba_pkg::OP_SPLIT;
      end
      bba_pkg::OP_REM0: state_next = bba_pkg::OP_REM1;
      bba_pkg::OP_REM1: state_next = bba_pkg::OP_REM2;
      bba_pkg::OP_REM2: begin
        state_next = stat.mode_free ? bba_pkg::OP_FLOOP : bba_pkg::OP_SPLIT;
      end
      bba_pkg::OP_FSTART: begin
        if (stat.oor) state_next = bba_pkg::OP_FINISH;
        else if (stat.cls_top) state_next = bba_pkg::OP_FLOOP;
        else state_next = bba_pkg::OP_FMARK;
      end
      bba_pkg::OP_FMARK: begin
        state_next = stat.marked ? bba_pkg::OP_FINISH : bba_pkg::OP_FLOOP;
      end
      bba_pkg::OP_FLOOP: begin
        state_next = stat.cls_top ? bba_pkg::OP_FINISH : bba_pkg::OP_MEVAL;
      end
      bba_pkg::OP_MEVAL: begin
        state_next = stat.merge_ok ? bba_pkg::OP_REM0 : bba_pkg::OP_PUSH0;
      end
      bba_pkg::OP_FINISH: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = bba_pkg::OP_IDLE;
        end
      end
      default: state_next = bba_pkg::OP_CLEAR;
    endcase
  end

endmodule

// File: src/bba_dp.sv
// Datapath of the buddy block allocator: list heads, lengths, counters,
// link, mark and frame-stack memories. Depends on bba_pkg and bba_ram.
module bba_dp #(
  parameter int SIZE_CLASSES = bba_pkg::SIZE_CLASSES_DEF,
  parameter int FRAME_COUNT  = bba_pkg::FRAME_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bba_pkg::cmd_t                     cmd,
  output bba_pkg::stat_t                    stat,
  input  logic                              mode,
  input  logic [bba_pkg::CLASS_FIELD_W-1:0] size_class,
  input  logic [bba_pkg::ADDR_FIELD_W-1:0]  block_addr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic [bba_pkg::ADDR_FIELD_W-1:0]  granted_addr,
  input  logic                              cfg_we,
  input  logic [bba_pkg::THR_W-1:0]         cfg_data,
  output logic [bba_pkg::THR_W-1:0]         threshold
);

  localparam int TOTAL  = FRAME_COUNT << SIZE_CLASSES;
  localparam int BLK_W  = $clog2(TOTAL + 1);
  localparam int AW     = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int CLS_W  = $clog2(SIZE_CLASSES + 1);
  localparam int CI_W   = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int RC_W   = $clog2(FRAME_COUNT + 1);
  localparam int FR_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int MW     = bba_pkg::MARK_CLASS_W + 1;
  localparam logic [BLK_W-1:0] NIL = BLK_W'(TOTAL);
  localparam logic [CLS_W-1:0] CLS_TOP = CLS_W'(SIZE_CLASSES);

  logic [BLK_W-1:0] head [SIZE_CLASSES];
  logic [bba_pkg::LEN_W-1:0] len [SIZE_CLASSES];

  logic             mode_r, oor, fail;
  logic [CLS_W-1:0] tgt, cls;
  logic [BLK_W-1:0] addr, node, hd, pv, nx;
  logic [RC_W-1:0]  ret_cnt, issued;
  logic [AW-1:0]    clr;

  logic [CLS_W-1:0] in_cls, cls_dec, cls_inc;
  logic [CI_W-1:0]  ci;
  logic [BLK_W-1:0] buddy, head_cur;
  logic             cls_top;

  // Memory ports.
  logic             nx_we, pv_we, mk_we, rf_we;
  logic [AW-1:0]    nx_wa, pv_wa, mk_wa, mk_ra;
  logic [BLK_W-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
  logic [MW-1:0]    mk_wd, mk_rd;
  logic [FR_W-1:0]  rf_wa, rf_ra, rf_wd, rf_rd;

  always_comb begin
    if (int'(size_class) > SIZE_CLASSES) in_cls = CLS_TOP;
    else in_cls = CLS_W'(size_class);
  end

  assign cls_top  = (cls >= CLS_TOP);
  assign ci       = cls[CI_W-1:0];
  assign head_cur = cls_top ? NIL : head[ci];
  assign cls_dec  = cls - CLS_W'(1);
  assign cls_inc  = cls + CLS_W'(1);
  assign buddy    = addr ^ (BLK_W'(1) << cls);

  always_comb begin
    stat.in_free     = mode;
    stat.mode_free   = mode_r;
    stat.oor         = oor;
    stat.scan_hit    = !cls_top && (head_cur < NIL);
    stat.cls_top     = cls_top;
    stat.ret_avail   = (ret_cnt != '0);
    stat.fresh_avail = (int'(issued) < FRAME_COUNT);
    stat.split_more  = (cls > tgt);
    stat.marked      = mk_rd[MW-1];
    stat.merge_ok    = !cls_top && (len[ci] >= threshold) && (buddy < NIL) &&
                       mk_rd[MW-1] &&
                       (mk_rd[MW-2:0] == bba_pkg::MARK_CLASS_W'(cls));
    stat.clear_last  = (clr == AW'(TOTAL - 1));
    stat.out_busy    = out_valid && !out_ready;
  end

  // Memory port selection per sequencer step.
  always_comb begin
    nx_we = 1'b0; nx_wa = node[AW-1:0]; nx_wd = head_cur;
    pv_we = 1'b0; pv_wa = node[AW-1:0]; pv_wd = NIL;
    mk_we = 1'b0; mk_wa = node[AW-1:0]; mk_wd = '0;
    mk_ra = addr[AW-1:0];
    rf_we = 1'b0;
    rf_wa = ret_cnt[FR_W-1:0];
    rf_wd = FR_W'(addr >> SIZE_CLASSES);
    rf_ra = FR_W'(ret_cnt - RC_W'(1));
    case (cmd.op)
      bba_pkg::OP_CLEAR: begin
        mk_we = 1'b1;
        mk_wa = clr;
      end
      bba_pkg::OP_PUSH0: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
        mk_we = 1'b1;
        mk_wd = {1'b1, bba_pkg::MARK_CLASS_W'(cls)};
      end
      bba_pkg::OP_PUSH1: begin
        pv_we = (hd < NIL);
        pv_wa = hd[AW-1:0];
        pv_wd = node;
      end
      bba_pkg::OP_REM1: begin
        // Unlink: predecessor (if any) now points past the removed node.
        nx_we = (pv_rd < NIL);
        nx_wa = pv_rd[AW-1:0];
        nx_wd = nx_rd;
        mk_we = 1'b1;
      end
      bba_pkg::OP_REM2: begin
        pv_we = (nx < NIL);
        pv_wa = nx[AW-1:0];
        pv_wd = (pv < NIL) ? pv : NIL;
      end
      bba_pkg::OP_FLOOP: begin
        mk_ra = buddy[AW-1:0];
        rf_we = cls_top && (int'(ret_cnt) < FRAME_COUNT);
      end
      default: ;
    endcase
  end

  bba_ram #(.WIDTH(BLK_W), .DEPTH(TOTAL)) u_next (
    .clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(node[AW-1:0]), .rdata(nx_rd)
  );
  bba_ram #(.WIDTH(BLK_W), .DEPTH(TOTAL)) u_prev (
    .clk, .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(node[AW-1:0]), .rdata(pv_rd)
  );
  bba_ram #(.WIDTH(MW), .DEPTH(TOTAL)) u_mark (
    .clk, .we(mk_we), .waddr(mk_wa), .wdata(mk_wd), .raddr(mk_ra), .rdata(mk_rd)
  );
  bba_ram #(.WIDTH(FR_W), .DEPTH(FRAME_COUNT)) u_frames (
    .clk, .we(rf_we), .waddr(rf_wa), .wdata(rf_wd), .raddr(rf_ra), .rdata(rf_rd)
  );

  // Control state: list heads, lengths, frame counters, sweep, threshold, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIZE_CLASSES; i++) begin
        head[i] <= NIL;
        len[i]  <= '0;
      end
      ret_cnt   <= '0;
      issued    <= '0;
      clr       <= '0;
      out_valid <= 1'b0;
      threshold <= bba_pkg::THRESHOLD_RESET;
    end else begin
      if (cfg_we) threshold <= cfg_data;
      case (cmd.op)
        bba_pkg::OP_CLEAR: clr <= clr + AW'(1);
        bba_pkg::OP_SCAN: begin
          if (cls_top) begin
            if (ret_cnt != '0) ret_cnt <= ret_cnt - RC_W'(1);
            else if (int'(issued) < FRAME_COUNT) issued <= issued + RC_W'(1);
          end
        end
        bba_pkg::OP_PUSH1: begin
          head[ci] <= node;
          if (len[ci] != bba_pkg::LEN_MAX) len[ci] <= len[ci] + bba_pkg::LEN_W'(1);
        end
        bba_pkg::OP_REM1: begin
          if (!(pv_rd < NIL)) head[ci] <= (nx_rd < NIL) ? nx_rd : NIL;
          if (len[ci] != '0) len[ci] <= len[ci] - bba_pkg::LEN_W'(1);
        end
        bba_pkg::OP_FLOOP: begin
          if (cls_top && int'(ret_cnt) < FRAME_COUNT) ret_cnt <= ret_cnt + RC_W'(1);
        end
        default: ;
      endcase
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= mode;
      oor    <= (int'(block_addr) >= TOTAL);
      fail   <= 1'b0;
      tgt    <= in_cls;
      cls    <= in_cls;
      addr   <= BLK_W'(block_addr) & ~((BLK_W'(1) << in_cls) - BLK_W'(1));
    end
    case (cmd.op)
      bba_pkg::OP_SCAN: begin
        if (!cls_top && head_cur < NIL) begin
          node <= head_cur;
          addr <= head_cur;
        end else if (!cls_top) begin
          cls <= cls_inc;
        end else if (ret_cnt == '0) begin
          if (int'(issued) < FRAME_COUNT) addr <= BLK_W'(issued) << SIZE_CLASSES;
          else fail <= 1'b1;
        end
      end
      bba_pkg::OP_FRAME_LD: addr <= BLK_W'(rf_rd) << SIZE_CLASSES;
      bba_pkg::OP_SPLIT: begin
        if (cls > tgt) begin
          cls  <= cls_dec;
          node <= addr + (BLK_W'(1) << cls_dec);
        end
      end
      bba_pkg::OP_PUSH0: hd <= head_cur;
      bba_pkg::OP_REM1: begin
        pv <= pv_rd;
        nx <= nx_rd;
      end
      bba_pkg::OP_REM2: begin
        if (mode_r) begin
          cls  <= cls_inc;
          addr <= addr & ~((BLK_W'(1) << cls_inc) - BLK_W'(1));
        end
      end
      bba_pkg::OP_MEVAL: node <= stat.merge_ok ? buddy : addr;
      default: ;
    endcase
    if (cmd.load_out) begin
      status       <= fail;
      granted_addr <= (!mode_r && !fail) ? bba_pkg::ADDR_FIELD_W'(addr) : '0;
    end
  end

endmodule

// File: src/buddy_block_allocator.sv
// Buddy block allocator: sequencer plus datapath over link, mark and frame memories.
// An allocation scans the classes upward, then takes a list head, reloads a returned frame
// or issues a fresh one, and splits down to the requested class; a free merges with its
// buddy while it can, and a double free or a whole frame ends without merging.
// One item at a time: the next is taken in the cycle after the result loads; a stalled result
// waits. Reset starts a sweep clearing the free marks of all FRAME_COUNT << SIZE_CLASSES blocks.
module buddy_block_allocator #(
  parameter int SIZE_CLASSES = bba_pkg::SIZE_CLASSES_DEF,
  parameter int FRAME_COUNT  = bba_pkg::FRAME_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic [bba_pkg::CLASS_FIELD_W-1:0] size_class,
  input  logic [bba_pkg::ADDR_FIELD_W-1:0]  block_addr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic [bba_pkg::ADDR_FIELD_W-1:0]  granted_addr,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [1:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

`include "buddy_block_allocator_macros.svh"

  bba_pkg::cmd_t  cmd;
  bba_pkg::stat_t stat;
  logic           cfg_we;
  logic [bba_pkg::THR_W-1:0] threshold;

  // Only one register: every word address maps onto the threshold.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == paddr);
  assign prdata = 32'(threshold);

  bba_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .stat, .cmd
  );

  bba_dp #(.SIZE_CLASSES(SIZE_CLASSES), .FRAME_COUNT(FRAME_COUNT)) u_dp (
    .clk, .rst, .cmd, .stat, .mode, .size_class, .block_addr,
    .out_valid, .out_ready, .status, .granted_addr,
    .cfg_we, .cfg_data(pwdata[bba_pkg::THR_W-1:0]), .threshold
  );

  `BBA_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
  `BBA_ASSERT_NOW(a_fail_zero, out_valid && status, granted_addr == '0, "failed beat has address")
  `BBA_ASSERT_NOW(a_no_overwrite, cmd.load_out, !(out_valid && !out_ready), "result overwritten")

endmodule

// File: sim/tb_buddy_block_allocator.sv
// Self-checking testbench for buddy_block_allocator: drives allocate and free
// requests, predicts each response from a behavioral allocator, checks it.
// Depends on bba_pkg and the buddy_block_allocator RTL.
`timescale 1ns / 1ps

module tb_buddy_block_allocator;

  localparam int NCLS     = bba_pkg::SIZE_CLASSES_DEF;
  localparam int NFRAMES  = bba_pkg::FRAME_COUNT_DEF;
  localparam int NBLOCKS  = NFRAMES << NCLS;
  localparam int NIL      = NBLOCKS;
  localparam int WDOG_MAX = NBLOCKS * 4 + 20000;
  localparam logic [1:0] REG_MERGE_THRESHOLD = 2'd0;
  localparam logic       MODE_ALLOC = 1'b0;
  localparam logic       MODE_FREE  = 1'b1;
  localparam logic       STAT_DONE  = 1'b0;
  localparam logic       STAT_NOFRAME = 1'b1;

  typedef struct packed {
    logic                             status;
    logic [bba_pkg::ADDR_FIELD_W-1:0] addr;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  logic [bba_pkg::CLASS_FIELD_W-1:0] size_class = '0;
  logic [bba_pkg::ADDR_FIELD_W-1:0] block_addr = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic status;
  logic [bba_pkg::ADDR_FIELD_W-1:0] granted_addr;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  buddy_block_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .size_class(size_class), .block_addr(block_addr),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .granted_addr(granted_addr),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Shadow allocator state.
  int unsigned thr;
  int unsigned head[NCLS];
  int unsigned llen[NCLS];
  int unsigned nxt[NBLOCKS];
  int unsigned prv[NBLOCKS];
  bit          fmark[NBLOCKS];
  int unsigned fcls[NBLOCKS];
  int unsigned issued;
  int unsigned ret_stack[NFRAMES];
  int unsigned ret_cnt;

  resp_t expected_resp[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stall_en = 1'b1;
  int unsigned live[$];   // addresses handed out; live_cls holds their classes
  int unsigned live_cls[$];

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void shadow_reset();
    thr = bba_pkg::THRESHOLD_RESET;
    for (int c = 0; c < NCLS; c++) begin
      head[c] = NIL;
      llen[c] = 0;
    end
    for (int i = 0; i < NBLOCKS; i++) begin
      nxt[i] = 0; prv[i] = 0; fmark[i] = 0; fcls[i] = 0;
    end
    issued = 0;
    ret_cnt = 0;
  endfunction

  function automatic void list_push(int unsigned a, int unsigned c);
    int unsigned h;
    h = head[c];
    nxt[a] = h;
    prv[a] = NIL;
    if (h < NBLOCKS) prv[h] = a;
    head[c] = a;
    if (llen[c] < bba_pkg::LEN_MAX) llen[c]++;
    fmark[a] = 1;
    fcls[a] = c & 7;
  endfunction

  function automatic void list_unlink(int unsigned a, int unsigned c);
    int unsigned p, n;
    p = prv[a];
    n = nxt[a];
    if (p < NBLOCKS) nxt[p] = n;
    else head[c] = (n < NBLOCKS) ? n : NIL;
    if (n < NBLOCKS) prv[n] = (p < NBLOCKS) ? p : NIL;
    if (llen[c] > 0) llen[c]--;
    fmark[a] = 0;
  endfunction

  function automatic resp_t predict_grant(logic md, logic [2:0] sc, logic [9:0] ba);
    resp_t r;
    int unsigned c, a, j, base, b, f;
    bit found;
    r = '0;
    c = (sc > NCLS) ? NCLS : sc;
    a = ba;
    if (md == MODE_ALLOC) begin
      found = 0;
      base = 0;
      j = c;
      for (int k = c; k < NCLS; k++) begin
        if (head[k] < NBLOCKS) begin
          base = head[k];
          list_unlink(base, k);
          j = k;
          found = 1;
          break;
        end
      end
      if (!found) begin
        if (ret_cnt > 0) begin
          ret_cnt--;
          f = ret_stack[ret_cnt] % NFRAMES;
        end else if (issued < NFRAMES) begin
          f = issued++;
        end else begin
          r.status = STAT_NOFRAME;
          return r;
        end
        base = f << NCLS;
        j = NCLS;
      end
      while (j > c) begin
        j--;
        list_push(base + (1 << j), j);
      end
      r.addr = base;
      return r;
    end
    if (a >= NBLOCKS) return r;
    a &= ~((1 << c) - 1);
    if (c < NCLS && fmark[a]) return r;
    forever begin
      if (c >= NCLS) begin
        if (ret_cnt < NFRAMES) ret_stack[ret_cnt++] = a >> NCLS;
        return r;
      end
      b = a ^ (1 << c);
      if (llen[c] < thr || b >= NBLOCKS || !fmark[b] || fcls[b] != c) begin
        list_push(a, c);
        return r;
      end
      list_unlink(b, c);
      c++;
      a &= ~((1 << c) - 1);
    end
  endfunction

  task automatic send_request(input logic md, input logic [2:0] sc, input logic [9:0] ba);
    resp_t r;
    mode <= md;
    size_class <= sc;
    block_addr <= ba;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    r = predict_grant(md, sc, ba);
    expected_resp.push_back(r);
    if (md == MODE_ALLOC && r.status == STAT_DONE) begin
      live.push_back(r.addr);
      live_cls.push_back((sc > NCLS) ? NCLS : sc);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    // The block takes one item at a time, so the next beat waits.
    @(negedge clk);
  endtask

  task automatic drain();
    while (expected_resp.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_threshold(input int unsigned v);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_MERGE_THRESHOLD; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    thr = v & 11'h7FF;
  endtask

  // Free a random block handed out earlier, at its own class.
  task automatic free_live();
    int k;
    int unsigned a, c;
    k = $urandom_range(live.size() - 1);
    a = live[k];
    c = live_cls[k];
    live.delete(k);
    live_cls.delete(k);
    send_request(MODE_FREE, c, a);
  endtask

  task automatic random_gap();
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 8)) @(negedge clk);
  endtask

  task automatic test_directed();
    send_request(MODE_ALLOC, 3'd0, 10'h3FF);
    send_request(MODE_ALLOC, 3'd4, 10'd0);
    send_request(MODE_ALLOC, 3'd7, 10'd0);
    send_request(MODE_ALLOC, 3'd2, 10'd0);
    send_request(MODE_ALLOC, 3'd1, 10'd0);
    send_request(MODE_FREE, 3'd0, 10'd0);
    send_request(MODE_FREE, 3'd0, 10'd0);      // double free
    send_request(MODE_FREE, 3'd0, 10'h3FF);    // never allocated, top of memory
    send_request(MODE_FREE, 3'd2, 10'd7);      // misaligned
    send_request(MODE_FREE, 3'd6, 10'd17);     // oversized class
    send_request(MODE_FREE, 3'd4, 10'd32);
    send_request(MODE_ALLOC, 3'd4, 10'd0);
    send_request(MODE_ALLOC, 3'd3, 10'd0);
    live.delete();
    live_cls.delete();
  endtask

  // Exhaust the frame pool, then return everything with merging enabled.
  task automatic test_exhaust_and_merge();
    write_threshold(0);
    for (int i = 0; i < NFRAMES + 3; i++) send_request(MODE_ALLOC, 3'd4, '0);
    send_request(MODE_ALLOC, 3'd0, '0);
    while (live.size() > 0) begin
      free_live();
      random_gap();
    end
  endtask

  task automatic test_random(input int n, input int unsigned t);
    write_threshold(t);
    for (int i = 0; i < n; i++) begin
      if (i % 40 < 20) stall_en = 1'b1;
      else stall_en = (i % 80 < 60);
      if ($urandom_range(9) == 0)
        send_request($urandom_range(1), $urandom_range(7), $urandom_range(1023));
      else if (live.size() > 0 && $urandom_range(1))
        free_live();
      else
        send_request(MODE_ALLOC, $urandom_range(4), $urandom);
      if (stall_en) random_gap();
    end
    while (live.size() > 0) free_live();
  endtask

  // Response checker: receiver stalls on its own pattern.
  always @(posedge clk) begin
    resp_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_resp.size() == 0) begin
        report("response with no request outstanding");
      end else begin
        e = expected_resp.pop_front();
        if (status !== e.status)
          report($sformatf("status %0b, want %0b", status, e.status));
        if (granted_addr !== e.addr)
          report($sformatf("granted_addr %0d, want %0d", granted_addr, e.addr));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (!stall_en) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(3) != 0);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    shadow_reset();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_exhaust_and_merge();
    test_random(120, 16);
    test_random(120, 2047);
    test_random(120, 1);
    drain();
    if (expected_resp.size() != 0) report("responses still outstanding");
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/bba_pkg.sv
src/bba_ram.sv
src/bba_ctrl.sv
src/bba_dp.sv
src/buddy_block_allocator.sv
sim/tb_buddy_block_allocator.sv
